// ===== src/ibwt_pkg.sv =====
// Shared constants, types and command/status structs for the inverse BWT block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package ibwt_pkg;

    // Largest block in bytes; the address and length widths follow from it.
    localparam int BLOCK_SIZE = 4096;
    localparam int ADDR_W     = $clog2(BLOCK_SIZE);
    localparam int LEN_W      = $clog2(BLOCK_SIZE + 1);
    localparam int SYM_W      = 8;
    localparam int NUM_SYM    = 256;
    localparam int TAB_AW     = $clog2(NUM_SYM);
    localparam int POS_W      = 12;
    localparam int PIDX_W     = 12;
    localparam int CMP_W      = (LEN_W > PIDX_W) ? LEN_W : PIDX_W;
    localparam int STORE_W    = SYM_W + ADDR_W;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_LOAD_WR,
        ST_ERR_OUT,
        ST_PFX_RD,
        ST_PFX_WR,
        ST_DRAIN,
        ST_DR_SYM,
        ST_DR_OUT
    } t_state;

    // Source of the symbol table read address.
    typedef enum logic [1:0] {
        TS_INPUT,
        TS_PFX,
        TS_SYM
    } t_tsel;

    typedef struct packed {
        logic  capture;
        logic  load_wr;
        logic  pfx_wr;
        logic  out_walk;
        logic  out_err;
        logic  blk_clear;
        t_tsel tsel;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic bad;
        logic pfx_done;
        logic rem_zero;
        logic rem_one;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== src/ibwt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stands alone; used for the byte/rank store and the symbol table.
`default_nettype none

module ibwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== src/ibwt_ctrl.sv =====
// Controller state machine for the inverse BWT block: sequences loads, the
// offset pass and the walk. Depends on ibwt_pkg for states, commands and status.
`default_nettype none

module ibwt_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_kind,
    input  wire ibwt_pkg::t_stat i_stat,
    output logic                o_in_stall,
    output ibwt_pkg::t_cmd      o_cmd
);

    ibwt_pkg::t_state r_state;
    ibwt_pkg::t_state n_state;
    logic             accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ibwt_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = !((r_state == ibwt_pkg::ST_LOAD) || (r_state == ibwt_pkg::ST_DRAIN));
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '{capture: 1'b0, load_wr: 1'b0, pfx_wr: 1'b0, out_walk: 1'b0,
                    out_err: 1'b0, blk_clear: 1'b0, tsel: ibwt_pkg::TS_SYM};
        case (r_state)
            ibwt_pkg::ST_LOAD: begin
                o_cmd.tsel = ibwt_pkg::TS_INPUT;
                // A drain word while loading is taken and dropped.
                if (accept && !i_kind) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ibwt_pkg::ST_LOAD_WR;
                end
            end
            ibwt_pkg::ST_LOAD_WR: begin
                o_cmd.load_wr = 1'b1;
                if (!i_stat.last) begin
                    n_state = ibwt_pkg::ST_LOAD;
                end else if (i_stat.bad) begin
                    n_state = ibwt_pkg::ST_ERR_OUT;
                end else begin
                    n_state = ibwt_pkg::ST_PFX_RD;
                end
            end
            ibwt_pkg::ST_ERR_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_err   = 1'b1;
                    o_cmd.blk_clear = 1'b1;
                    n_state         = ibwt_pkg::ST_LOAD;
                end
            end
            ibwt_pkg::ST_PFX_RD: begin
                o_cmd.tsel = ibwt_pkg::TS_PFX;
                n_state    = ibwt_pkg::ST_PFX_WR;
            end
            ibwt_pkg::ST_PFX_WR: begin
                o_cmd.pfx_wr = 1'b1;
                n_state = i_stat.pfx_done ? ibwt_pkg::ST_DRAIN : ibwt_pkg::ST_PFX_RD;
            end
            ibwt_pkg::ST_DRAIN: begin
                // A load word while draining is taken and dropped.
                if (accept && i_kind && !i_stat.rem_zero) begin
                    n_state = ibwt_pkg::ST_DR_SYM;
                end
            end
            ibwt_pkg::ST_DR_SYM: begin
                n_state = ibwt_pkg::ST_DR_OUT;
            end
            ibwt_pkg::ST_DR_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_walk = 1'b1;
                    if (i_stat.rem_one) begin
                        o_cmd.blk_clear = 1'b1;
                        n_state         = ibwt_pkg::ST_LOAD;
                    end else begin
                        n_state = ibwt_pkg::ST_DRAIN;
                    end
                end
            end
            default: begin
                n_state = ibwt_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/ibwt_dp.sv =====
// Datapath for the inverse BWT block: byte/rank store, symbol table with valid
// bits, counters and the output register. Depends on ibwt_pkg and ibwt_ram.
`default_nettype none

module ibwt_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ibwt_pkg::t_cmd                i_cmd,
    input  wire logic [ibwt_pkg::SYM_W-1:0]    i_data_byte,
    input  wire logic                          i_last,
    input  wire logic [ibwt_pkg::PIDX_W-1:0]   i_primary_index,
    input  wire logic                          i_out_stall,
    output ibwt_pkg::t_stat                    o_stat,
    output logic                               o_out_valid,
    output logic      [ibwt_pkg::SYM_W-1:0]    o_out_byte,
    output logic      [ibwt_pkg::POS_W-1:0]    o_position,
    output logic                               o_out_last,
    output logic                               o_error
);

    localparam int AW  = ibwt_pkg::ADDR_W;
    localparam int LW  = ibwt_pkg::LEN_W;
    localparam int SW  = ibwt_pkg::SYM_W;
    localparam int TAW = ibwt_pkg::TAB_AW;
    localparam int CW  = ibwt_pkg::CMP_W;

    // Captured load word.
    logic [SW-1:0]                 r_in_sym;
    logic                          r_in_last;
    logic [ibwt_pkg::PIDX_W-1:0]   r_in_pidx;

    logic [LW-1:0]                 r_len;
    logic                          r_err;
    logic [AW-1:0]                 r_walk;
    logic [LW-1:0]                 r_rem;
    logic [TAW-1:0]                r_k;
    logic [LW-1:0]                 r_sum;
    logic [ibwt_pkg::NUM_SYM-1:0]  r_tvalid;
    logic                          r_tv_q;

    logic                          r_ovalid;
    logic [SW-1:0]                 r_obyte;
    logic [ibwt_pkg::POS_W-1:0]    r_opos;
    logic                          r_olast;
    logic                          r_oerr;

    logic [ibwt_pkg::STORE_W-1:0]  st_rdata;
    logic [ibwt_pkg::STORE_W-1:0]  st_wdata;
    logic                          st_we;
    logic [LW-1:0]                 tab_rdata;
    logic [LW-1:0]                 tab_wdata;
    logic [TAW-1:0]                tab_waddr;
    logic [TAW-1:0]                tab_raddr;
    logic                          tab_we;

    logic [LW-1:0]                 tval;
    logic                          full;
    logic [LW-1:0]                 len_new;
    logic                          err_new;
    logic [TAW-1:0]                pfx_sym;
    logic [SW-1:0]                 walk_sym;
    logic [AW-1:0]                 walk_rank;
    logic [LW-1:0]                 next_idx;
    logic [AW-1:0]                 walk_next;
    logic [LW-1:0]                 rem_dec;
    logic                          out_free;

    // Entries not yet written since the block was cleared count as zero.
    assign tval     = r_tv_q ? tab_rdata : '0;
    assign full     = (r_len == LW'(ibwt_pkg::BLOCK_SIZE));
    assign len_new  = full ? r_len : r_len + LW'(1);
    assign err_new  = r_err || full;
    // Offsets run in signed-byte order: 0x80..0xFF, then 0x00..0x7F.
    assign pfx_sym  = {~r_k[TAW-1], r_k[TAW-2:0]};
    assign walk_sym  = st_rdata[ibwt_pkg::STORE_W-1:AW];
    assign walk_rank = st_rdata[AW-1:0];
    assign next_idx  = LW'(walk_rank) + tval;
    assign walk_next = (next_idx >= LW'(ibwt_pkg::BLOCK_SIZE)) ? '0 : next_idx[AW-1:0];
    assign rem_dec   = r_rem - LW'(1);
    assign out_free  = !r_ovalid || !i_out_stall;

    assign st_we    = i_cmd.load_wr && !full;
    assign st_wdata = {r_in_sym, tval[AW-1:0]};

    always_comb begin
        case (i_cmd.tsel)
            ibwt_pkg::TS_INPUT: tab_raddr = i_data_byte;
            ibwt_pkg::TS_PFX:   tab_raddr = pfx_sym;
            ibwt_pkg::TS_SYM:   tab_raddr = walk_sym;
            default:            tab_raddr = walk_sym;
        endcase
    end

    always_comb begin
        if (i_cmd.pfx_wr) begin
            tab_we    = 1'b1;
            tab_waddr = pfx_sym;
            tab_wdata = r_sum;
        end else begin
            tab_we    = i_cmd.load_wr && !full;
            tab_waddr = r_in_sym;
            tab_wdata = tval + LW'(1);
        end
    end

    ibwt_ram #(
        .WIDTH (ibwt_pkg::STORE_W),
        .DEPTH (ibwt_pkg::BLOCK_SIZE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (st_wdata),
        .i_raddr (r_walk),
        .o_rdata (st_rdata)
    );

    ibwt_ram #(
        .WIDTH (LW),
        .DEPTH (ibwt_pkg::NUM_SYM)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rdata)
    );

    always_ff @(posedge i_clk) begin
        r_tv_q <= r_tvalid[tab_raddr];
        if (i_cmd.capture) begin
            r_in_sym  <= i_data_byte;
            r_in_last <= i_last;
            r_in_pidx <= i_primary_index;
        end
        if (i_cmd.load_wr) begin
            r_k   <= '0;
            r_sum <= '0;
        end
        if (i_cmd.pfx_wr) begin
            r_k   <= r_k + TAW'(1);
            r_sum <= r_sum + tval;
        end
        if (i_cmd.out_walk) begin
            r_obyte <= walk_sym;
            r_opos  <= ibwt_pkg::POS_W'(rem_dec);
            r_olast <= (rem_dec == '0);
            r_oerr  <= 1'b0;
        end else if (i_cmd.out_err) begin
            r_obyte <= '0;
            r_opos  <= '0;
            r_olast <= 1'b1;
            r_oerr  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_err    <= 1'b0;
            r_walk   <= '0;
            r_rem    <= '0;
            r_tvalid <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.out_walk || i_cmd.out_err) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.load_wr) begin
                r_len <= len_new;
                r_err <= err_new;
                if (!full) begin
                    r_tvalid[r_in_sym] <= 1'b1;
                end
                if (r_in_last) begin
                    r_walk <= AW'(r_in_pidx);
                    r_rem  <= len_new;
                end
            end
            if (i_cmd.pfx_wr) begin
                r_tvalid[pfx_sym] <= 1'b1;
            end
            if (i_cmd.blk_clear) begin
                r_len    <= '0;
                r_err    <= 1'b0;
                r_walk   <= '0;
                r_rem    <= '0;
                r_tvalid <= '0;
            end else if (i_cmd.out_walk) begin
                r_walk <= walk_next;
                r_rem  <= rem_dec;
            end
        end
    end

    assign o_stat.last     = r_in_last;
    assign o_stat.bad      = err_new || (CW'(r_in_pidx) >= CW'(len_new));
    assign o_stat.pfx_done = &r_k;
    assign o_stat.rem_zero = (r_rem == '0);
    assign o_stat.rem_one  = (r_rem == LW'(1));
    assign o_stat.out_free = out_free;

    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_position  = r_opos;
    assign o_out_last  = r_olast;
    assign o_error     = r_oerr;

`ifndef NO_ASSERTIONS
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_walk || i_cmd.out_err) |-> out_free)
        else $error("result loaded while output register still held a word");
    a_walk_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_walk |-> (r_rem != '0))
        else $error("walk step with no bytes remaining");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.blk_clear |=> (r_len == '0) && (r_tvalid == '0) && !r_err)
        else $error("block state not cleared");
    a_pfx_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pfx_wr && (&r_k)) |=> (&r_tvalid))
        else $error("offset pass left table entries unwritten");
`endif

endmodule

`default_nettype wire

// ===== src/inverse_burrows_wheeler.sv =====
// Top level of the inverse Burrows-Wheeler transform block.
// Joins ibwt_ctrl and ibwt_dp; depends on ibwt_pkg and, through the datapath, ibwt_ram.
//
//  Channel   Direction  Handshake                 Word
//  input     in         i_in_valid / o_in_stall   i_kind, i_data_byte, i_last, i_primary_index
//  output    out        o_out_valid / i_out_stall o_out_byte, o_position, o_out_last, o_error
//
// A load word is handled as the symbol table read, then the store and count update.
// After a good last load, an offset pass runs over every table entry, a read and then a write for each.
// A drain word is handled as the store read, the symbol table read, then the result register.
// Reset is synchronous and active low; table validity lives in flip-flops, so no
// clearing pass is needed and the block accepts words right after reset.
// A stalled result holds the next result in its final state; input words are still
// taken while a finished result waits on the output.
`default_nettype none

module inverse_burrows_wheeler (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_kind,
    input  wire logic [ibwt_pkg::SYM_W-1:0]    i_data_byte,
    input  wire logic                          i_last,
    input  wire logic [ibwt_pkg::PIDX_W-1:0]   i_primary_index,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [ibwt_pkg::SYM_W-1:0]    o_out_byte,
    output logic      [ibwt_pkg::POS_W-1:0]    o_position,
    output logic                               o_out_last,
    output logic                               o_error
);

    // Commands flow from the controller to the datapath, status flows back.
    ibwt_pkg::t_cmd  cmd;
    ibwt_pkg::t_stat stat;

    // The controller decides which word is taken and what each cycle does.
    ibwt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // The datapath holds the stores, the counters and the result register.
    ibwt_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_data_byte     (i_data_byte),
        .i_last          (i_last),
        .i_primary_index (i_primary_index),
        .i_out_stall     (i_out_stall),
        .o_stat          (stat),
        .o_out_valid     (o_out_valid),
        .o_out_byte      (o_out_byte),
        .o_position      (o_position),
        .o_out_last      (o_out_last),
        .o_error         (o_error)
    );

endmodule

`default_nettype wire
